/* rtl/core/dtd_pkg.sv */
package dtd_pkg;

   // sizes of the item fields
   localparam int DIST_W   = 16;
   localparam int TIME_W   = 20;
   localparam int ANGLE_W  = 20;
   localparam int STATUS_W = 2;
   localparam int FRAC_W   = 16;

   // search depth and distance range
   localparam int BISECTION_STEPS = 16;
   localparam int DISTANCE_BITS   = 16;
   localparam int DIST_USED       = (DISTANCE_BITS < DIST_W) ? DISTANCE_BITS : DIST_W;
   localparam logic [DIST_W-1:0] DIST_MAX = DIST_W'((64'd1 << DIST_USED) - 64'd1);

   // short distance region
   localparam logic [DIST_W-1:0] SHORT_LIMIT = DIST_W'(410);
   localparam logic [TIME_W-1:0] SHORT_TIME  = TIME_W'(432);
   localparam logic [TIME_W-1:0] TIME_MAX    = {TIME_W{1'b1}};

   // angle folding, degrees in Q16
   localparam int RAD_W    = 30;
   localparam logic [RAD_W-1:0] RAD_TO_DEG_Q24 = RAD_W'(961263669);
   localparam int DEGRAW_W = 25;
   localparam int DEG_W    = 23;
   localparam longint Deg90 = 64'd90 * 64'd65536;
   localparam logic [DEG_W-1:0] DEG30 = DEG_W'(30 * 65536);
   localparam logic [DEG_W-1:0] DEG45 = DEG_W'(45 * 65536);
   localparam logic [DEG_W-1:0] DEG60 = DEG_W'(60 * 65536);
   localparam int FOLD_TURNS =
      int'((longint'(RAD_TO_DEG_Q24) >> (24 - (ANGLE_W - 1))) / Deg90);

   // blend fraction: divide by 15 through a reciprocal
   localparam int V_W = 20;
   localparam logic [16:0] RECIP15 = 17'd69905;

   // polynomial arithmetic
   localparam int COEF_W   = 26;
   localparam int R_W      = 42;
   localparam int HPROD_W  = R_W + DIST_W + 1;
   localparam int HORNER_N = 5;
   localparam int S_W      = 44;
   localparam longint SatLimit = 64'sd1 <<< 40;
   localparam int EVAL_LAT = HORNER_N + 3;

   typedef enum logic {
      OP_TIME,
      OP_DIST
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK,
      STATUS_RANGE,
      STATUS_NO_MAX
   } status_type;

   // one item on its way through the pipeline
   typedef struct packed {
      logic              valid;
      opcode_type        op;
      logic [DIST_W-1:0] dist_val;
      logic [TIME_W-1:0] t_in;
      logic [1:0]        seg;
      logic [FRAC_W-1:0] frac;
      logic [DIST_W-1:0] mx;
      logic [TIME_W-1:0] t_far;
      logic [TIME_W-1:0] t_short;
      logic [DIST_W-1:0] lo;
      logic [DIST_W-1:0] hi;
   } ctx_type;

   // curves at 0, 30, 45 and 60 degrees, Q2.24, constant term first
   localparam logic signed [COEF_W-1:0] COEF [4][6] = '{
      '{26'sd38135, 26'sd3099926, 26'sd85572, -26'sd34959, 26'sd6429, -26'sd312},
      '{-26'sd184437, 26'sd4017663, -26'sd726277, 26'sd231562, -26'sd30743, 26'sd1537},
      '{-26'sd267610, 26'sd4290614, -26'sd947046, 26'sd287357, -26'sd35729, 26'sd1693},
      '{-26'sd175815, 26'sd4194374, -26'sd863361, 26'sd274725, -26'sd36964, 26'sd1934}
   };

   function automatic logic [DIST_W-1:0] clamp_dist(input logic [DIST_W-1:0] d);
      return (d > DIST_MAX) ? DIST_MAX : d;
   endfunction

   // r = c + floor(r * x / 1024), saturated to +-2^40
   function automatic logic signed [R_W-1:0] horner_step(
      input logic signed [R_W-1:0]    r,
      input logic [DIST_W-1:0]        x,
      input logic signed [COEF_W-1:0] c
   );
      logic signed [HPROD_W-1:0] prod;
      logic signed [HPROD_W-1:0] acc;
      prod = r * $signed({1'b0, x});
      acc  = (prod >>> 10) + HPROD_W'(c);
      if (acc > HPROD_W'(SatLimit)) begin
         acc = HPROD_W'(SatLimit);
      end else if (acc < -HPROD_W'(SatLimit)) begin
         acc = -HPROD_W'(SatLimit);
      end
      return R_W'(acc);
   endfunction

endpackage

/* rtl/core/dtd_eval.sv */
module dtd_eval (
   input  logic                          clock,
   input  logic                          enable,
   input  logic [dtd_pkg::DIST_W-1:0]    x_in,
   input  logic [1:0]                    seg_in,
   input  logic [dtd_pkg::FRAC_W-1:0]    frac_in,
   output logic [dtd_pkg::TIME_W-1:0]    time_out
);
   import dtd_pkg::*;

   // horner stages, both curves side by side
   logic [DIST_W-1:0]     x_pipe_ff    [HORNER_N];
   logic [DIST_W-1:0]     x_pipe_in    [HORNER_N];
   logic [1:0]            seg_pipe_ff  [HORNER_N];
   logic [1:0]            seg_pipe_in  [HORNER_N];
   logic [FRAC_W-1:0]     frac_pipe_ff [HORNER_N];
   logic [FRAC_W-1:0]     frac_pipe_in [HORNER_N];
   logic signed [R_W-1:0] rl_ff        [HORNER_N];
   logic signed [R_W-1:0] rl_in        [HORNER_N];
   logic signed [R_W-1:0] rr_ff        [HORNER_N];
   logic signed [R_W-1:0] rr_in        [HORNER_N];

   for (genvar g = 0; g < HORNER_N; g++) begin : g_horner
      logic signed [R_W-1:0] rl_prev;
      logic signed [R_W-1:0] rr_prev;
      logic [1:0]            seg_right;

      if (g == 0) begin : g_first
         assign x_pipe_in[g]    = x_in;
         assign seg_pipe_in[g]  = seg_in;
         assign frac_pipe_in[g] = frac_in;
         assign rl_prev         = R_W'(COEF[seg_in][HORNER_N]);
         assign rr_prev         = R_W'(COEF[seg_in + 2'd1][HORNER_N]);
      end else begin : g_next
         assign x_pipe_in[g]    = x_pipe_ff[g-1];
         assign seg_pipe_in[g]  = seg_pipe_ff[g-1];
         assign frac_pipe_in[g] = frac_pipe_ff[g-1];
         assign rl_prev         = rl_ff[g-1];
         assign rr_prev         = rr_ff[g-1];
      end

      // right curve follows the left one, 60 degrees wraps back to 0
      assign seg_right = seg_pipe_in[g] + 2'd1;
      assign rl_in[g] = horner_step(rl_prev, x_pipe_in[g],
                                    COEF[seg_pipe_in[g]][HORNER_N-1-g]);
      assign rr_in[g] = horner_step(rr_prev, x_pipe_in[g],
                                    COEF[seg_right][HORNER_N-1-g]);

      always_ff @(posedge clock) begin
         if (enable) begin
            x_pipe_ff[g]    <= x_pipe_in[g];
            seg_pipe_ff[g]  <= seg_pipe_in[g];
            frac_pipe_ff[g] <= frac_pipe_in[g];
            rl_ff[g]        <= rl_in[g];
            rr_ff[g]        <= rr_in[g];
         end
      end
   end

   // difference of the two curves
   logic signed [R_W:0]   diff_ff,  diff_in;
   logic signed [R_W-1:0] pl_ff;
   logic [FRAC_W-1:0]     frac_d_ff;
   logic [DIST_W-1:0]     x_d_ff;

   assign diff_in = (R_W+1)'(rr_ff[HORNER_N-1]) - (R_W+1)'(rl_ff[HORNER_N-1]);

   always_ff @(posedge clock) begin
      if (enable) begin
         diff_ff   <= diff_in;
         pl_ff     <= rl_ff[HORNER_N-1];
         frac_d_ff <= frac_pipe_ff[HORNER_N-1];
         x_d_ff    <= x_pipe_ff[HORNER_N-1];
      end
   end

   // linear blend in angle
   logic signed [FRAC_W+R_W+1:0] blend_prod;
   logic signed [S_W-1:0]        blend_ff, blend_in;
   logic [DIST_W-1:0]            x_m_ff;

   assign blend_prod = $signed({1'b0, frac_d_ff}) * diff_ff;
   assign blend_in   = S_W'(pl_ff) + S_W'(blend_prod >>> FRAC_W);

   always_ff @(posedge clock) begin
      if (enable) begin
         blend_ff <= blend_in;
         x_m_ff   <= x_d_ff;
      end
   end

   // scale to 1/64 ns with rounding, then clamp; short distances give SHORT_TIME
   logic signed [S_W+13:0]  scaled;
   logic signed [S_W+13:0]  shifted;
   logic [TIME_W-1:0]       time_ff, time_in;

   assign scaled  = blend_ff * $signed(14'sd6400) + (S_W+14)'(64'sd1 <<< 23);
   assign shifted = scaled >>> 24;

   always_comb begin
      if (x_m_ff < SHORT_LIMIT) begin
         time_in = SHORT_TIME;
      end else if (shifted < 0) begin
         time_in = '0;
      end else if (shifted > (S_W+14)'(TIME_MAX)) begin
         time_in = TIME_MAX;
      end else begin
         time_in = shifted[TIME_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         time_ff <= time_in;
      end
   end

   assign time_out = time_ff;

endmodule

/* rtl/core/dtd_front.sv */
module dtd_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enable,
   input  logic                          in_valid,
   input  logic                          opcode,
   input  logic [dtd_pkg::DIST_W-1:0]    distance,
   input  logic [dtd_pkg::TIME_W-1:0]    drift_time,
   input  logic signed [dtd_pkg::ANGLE_W-1:0] angle,
   input  logic [dtd_pkg::DIST_W-1:0]    max_dist,
   output dtd_pkg::ctx_type              ctx_out
);
   import dtd_pkg::*;

   ctx_type c0_ff, c0_in, c1_ff, c2_ff, c3_ff, c3_in, c4_ff, c5_ff, c5_in;
   logic [ANGLE_W-1:0]   mag_ff, mag_in;
   logic [50:0]          deg_prod;
   logic [DEGRAW_W-1:0]  degraw_ff, degraw_in;
   logic [DEG_W-1:0]     deg_ff, deg_in;
   logic [V_W-1:0]       v_ff, v_in, v_d_ff;
   logic [36:0]          q_prod;
   logic [FRAC_W-1:0]    qest_ff, qest_in;

   // capture the item, absolute angle
   always_comb begin
      c0_in          = '0;
      c0_in.valid    = in_valid;
      c0_in.op       = opcode_type'(opcode);
      c0_in.dist_val = clamp_dist(distance);
      c0_in.t_in     = drift_time;
      c0_in.mx       = clamp_dist(max_dist);
      c0_in.lo       = SHORT_LIMIT;
      c0_in.hi       = clamp_dist(max_dist);
      mag_in         = ANGLE_W'(angle[ANGLE_W-1] ? -angle : angle);
   end

   // radians to degrees, rounded
   assign deg_prod  = 51'(mag_ff) * 51'(RAD_TO_DEG_Q24) + 51'(64'd1 << 23);
   assign degraw_in = deg_prod[24 +: DEGRAW_W];

   // fold modulo 90 degrees
   always_comb begin
      logic [DEGRAW_W-1:0] deg_sub;
      deg_sub = '0;
      for (int k = 1; k <= FOLD_TURNS; k++) begin
         if (degraw_ff >= DEGRAW_W'(longint'(k) * Deg90)) begin
            deg_sub = DEGRAW_W'(longint'(k) * Deg90);
         end
      end
      deg_in = DEG_W'(degraw_ff - deg_sub);
   end

   // pick the bracketing curves and offset into the segment
   always_comb begin
      logic [DEG_W-1:0] v_full;
      logic             halve;
      c3_in = c2_ff;
      if (deg_ff < DEG30) begin
         c3_in.seg = 2'd0;
         v_full    = deg_ff;
         halve     = 1'b1;
      end else if (deg_ff < DEG45) begin
         c3_in.seg = 2'd1;
         v_full    = deg_ff - DEG30;
         halve     = 1'b0;
      end else if (deg_ff < DEG60) begin
         c3_in.seg = 2'd2;
         v_full    = deg_ff - DEG45;
         halve     = 1'b0;
      end else begin
         c3_in.seg = 2'd3;
         v_full    = deg_ff - DEG60;
         halve     = 1'b1;
      end
      v_in = halve ? V_W'(v_full >> 1) : V_W'(v_full);
   end

   // quotient estimate by 15, low by at most one
   assign q_prod  = 37'(v_ff) * 37'(RECIP15);
   assign qest_in = q_prod[20 +: FRAC_W];

   // correct the quotient
   always_comb begin
      logic [V_W-1:0] rem;
      rem   = v_d_ff - ((V_W'(qest_ff) << 4) - V_W'(qest_ff));
      c5_in = c4_ff;
      c5_in.frac = (rem >= V_W'(15)) ? qest_ff + FRAC_W'(1) : qest_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c0_ff <= '0;
         c1_ff <= '0;
         c2_ff <= '0;
         c3_ff <= '0;
         c4_ff <= '0;
         c5_ff <= '0;
      end else if (enable) begin
         c0_ff <= c0_in;
         c1_ff <= c0_ff;
         c2_ff <= c1_ff;
         c3_ff <= c3_in;
         c4_ff <= c3_ff;
         c5_ff <= c5_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         mag_ff    <= mag_in;
         degraw_ff <= degraw_in;
         deg_ff    <= deg_in;
         v_ff      <= v_in;
         v_d_ff    <= v_ff;
         qest_ff   <= qest_in;
      end
   end

   assign ctx_out = c5_ff;

endmodule

/* rtl/core/dtd_cell.sv */
module dtd_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  dtd_pkg::ctx_type ctx_in,
   output dtd_pkg::ctx_type ctx_out
);
   import dtd_pkg::*;

   logic [DIST_W:0]   mid_sum;
   logic [DIST_W-1:0] mid;
   logic [TIME_W-1:0] t_mid;
   ctx_type           dly_ff [EVAL_LAT];
   logic [DIST_W-1:0] mid_ff [EVAL_LAT];
   ctx_type           out_ff, out_in;

   // probe point halfway between the bounds
   assign mid_sum = {1'b0, ctx_in.lo} + {1'b0, ctx_in.hi};
   assign mid     = mid_sum[DIST_W:1];

   dtd_eval u_eval (
      .clock    (clock),
      .enable   (enable),
      .x_in     (mid),
      .seg_in   (ctx_in.seg),
      .frac_in  (ctx_in.frac),
      .time_out (t_mid)
   );

   // item waits beside the evaluation
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < EVAL_LAT; i++) begin
            dly_ff[i] <= '0;
         end
      end else if (enable) begin
         dly_ff[0] <= ctx_in;
         for (int i = 1; i < EVAL_LAT; i++) begin
            dly_ff[i] <= dly_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         mid_ff[0] <= mid;
         for (int i = 1; i < EVAL_LAT; i++) begin
            mid_ff[i] <= mid_ff[i-1];
         end
      end
   end

   // narrow the bracket
   always_comb begin
      out_in = dly_ff[EVAL_LAT-1];
      if (t_mid < dly_ff[EVAL_LAT-1].t_in) begin
         out_in.lo = mid_ff[EVAL_LAT-1];
      end else begin
         out_in.hi = mid_ff[EVAL_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff <= '0;
      end else if (enable) begin
         out_ff <= out_in;
      end
   end

   assign ctx_out = out_ff;

endmodule

/* rtl/core/drift_time_distance_converter.sv */
// Drift time / distance converter. Takes one item per clock unless the pipe is held by
// a result waiting at a full output, and returns one result per item, in order. With 16
// bisection steps and an 8-stage curve evaluator, an item passes through: a 6-stage
// angle front end, one evaluation of the end points, then a row of identical bisection
// cells, each with its own pipelined polynomial evaluator, then the output register.
// Opcode 0 returns time_out for distance_in; opcode 1 returns distance_out for time_in
// with a status. max_drift_distance is written through csr_write_enable/csr_write_data
// and must only change while no item is in flight.
module drift_time_distance_converter (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_opcode,
   input  logic [dtd_pkg::DIST_W-1:0]         req_distance_in,
   input  logic [dtd_pkg::TIME_W-1:0]         req_time_in,
   input  logic signed [dtd_pkg::ANGLE_W-1:0] req_track_angle,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [dtd_pkg::TIME_W-1:0]         rsp_time_out,
   output logic [dtd_pkg::DIST_W-1:0]         rsp_distance_out,
   output logic [dtd_pkg::STATUS_W-1:0]       rsp_status,
   input  logic                               csr_write_enable,
   input  logic [dtd_pkg::DIST_W-1:0]         csr_write_data
);
   import dtd_pkg::*;

   logic              enable;
   logic [DIST_W-1:0] max_dist_ff;
   ctx_type           front_ctx;
   ctx_type           init_ff [EVAL_LAT];
   logic [DIST_W-1:0] x_far;
   logic [TIME_W-1:0] t_far;
   logic [TIME_W-1:0] t_short;
   ctx_type           cell_ctx [BISECTION_STEPS+1];
   ctx_type           last;
   logic              out_valid_ff, out_valid_in;
   logic [TIME_W-1:0] out_time_ff, out_time_in;
   logic [DIST_W-1:0] out_dist_ff, out_dist_in;
   status_type        out_status_ff, out_status_in;
   logic [DIST_W:0]   fin_sum;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_dist_ff <= '0;
      end else if (csr_write_enable) begin
         max_dist_ff <= csr_write_data;
      end
   end

   // the whole pipe holds only when a finished item meets a full output
   assign last      = cell_ctx[BISECTION_STEPS];
   assign enable    = !(last.valid && out_valid_ff && !rsp_ready);
   assign req_ready = enable;

   dtd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .enable     (enable),
      .in_valid   (req_valid),
      .opcode     (req_opcode),
      .distance   (req_distance_in),
      .drift_time (req_time_in),
      .angle      (req_track_angle),
      .max_dist   (max_dist_ff),
      .ctx_out    (front_ctx)
   );

   // time at the input distance or at the maximum, and at the short limit
   assign x_far = (front_ctx.op == OP_DIST) ? front_ctx.mx : front_ctx.dist_val;

   dtd_eval u_eval_far (
      .clock    (clock),
      .enable   (enable),
      .x_in     (x_far),
      .seg_in   (front_ctx.seg),
      .frac_in  (front_ctx.frac),
      .time_out (t_far)
   );

   dtd_eval u_eval_short (
      .clock    (clock),
      .enable   (enable),
      .x_in     (SHORT_LIMIT),
      .seg_in   (front_ctx.seg),
      .frac_in  (front_ctx.frac),
      .time_out (t_short)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < EVAL_LAT; i++) begin
            init_ff[i] <= '0;
         end
      end else if (enable) begin
         init_ff[0] <= front_ctx;
         for (int i = 1; i < EVAL_LAT; i++) begin
            init_ff[i] <= init_ff[i-1];
         end
      end
   end

   always_comb begin
      cell_ctx[0]         = init_ff[EVAL_LAT-1];
      cell_ctx[0].t_far   = t_far;
      cell_ctx[0].t_short = t_short;
   end

   // row of bisection cells
   for (genvar g = 0; g < BISECTION_STEPS; g++) begin : g_cell
      dtd_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .enable  (enable),
         .ctx_in  (cell_ctx[g]),
         .ctx_out (cell_ctx[g+1])
      );
   end

   // result selection
   assign fin_sum = {1'b0, last.lo} + {1'b0, last.hi};

   always_comb begin
      out_time_in   = '0;
      out_dist_in   = '0;
      out_status_in = STATUS_OK;
      if (last.op == OP_TIME) begin
         out_time_in = last.t_far;
      end else if (last.mx == '0) begin
         out_status_in = STATUS_NO_MAX;
      end else if (last.t_in < SHORT_TIME || last.t_in > last.t_far) begin
         out_status_in = STATUS_RANGE;
      end else if (last.t_in > last.t_short) begin
         out_dist_in = fin_sum[DIST_W:1];
      end
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (enable && last.valid) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable && last.valid) begin
         out_time_ff   <= out_time_in;
         out_dist_ff   <= out_dist_in;
         out_status_ff <= out_status_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_time_out     = out_time_ff;
   assign rsp_distance_out = out_dist_ff;
   assign rsp_status       = out_status_ff;

   // a failed inversion carries no distance and no time
   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_status_ff != STATUS_OK |-> out_dist_ff == '0 && out_time_ff == '0)
      else $error("error status with nonzero payload");

   // a time result never carries a distance or a status
   a_time_only: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_time_ff != '0 |-> out_dist_ff == '0 && out_status_ff == STATUS_OK)
      else $error("time result mixed with inversion fields");

   // a waiting result is never overwritten by a finished item
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready && last.valid |-> !enable)
      else $error("pipeline advanced over a waiting result");

   // reset empties the output
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !out_valid_ff)
      else $error("output valid after reset");

endmodule
